@@ design/sh2e_pkg.sv @@
// Shared types, formats and constants of the order-2 SH RGB evaluator.
package sh2e_pkg;

  localparam int COEFF_BITS  = 24;
  localparam int NORMAL_BITS = 16;
  localparam int NFRAC       = NORMAL_BITS - 1;
  localparam int KSH         = 20;
  localparam int OUT_FRAC    = 16;
  localparam int NUM_COEFFS  = 9;
  localparam int NUM_CHAN    = 3;
  localparam int IDX_BITS    = 4;
  localparam int ONE_16      = 65536;

  // normal products, plus one bit of rounding headroom
  localparam int NPROD_BITS  = 2 * NORMAL_BITS + 1;
  localparam int NSHIFT      = 2 * NFRAC - OUT_FRAC;
  localparam int BASIS_BITS  = 18;
  localparam int BEXT_BITS   = 20;
  localparam int K_BITS      = 22;
  localparam int KMUL_BITS   = K_BITS + BEXT_BITS;
  localparam int WGT_BITS    = 18;
  localparam int CPROD_BITS  = COEFF_BITS + WGT_BITS;
  localparam int PSUM_BITS   = CPROD_BITS + 2;
  localparam int ACC_BITS    = CPROD_BITS + 4;

  typedef logic signed [COEFF_BITS-1:0]  coeff_t;
  typedef logic signed [NORMAL_BITS-1:0] normal_t;
  typedef logic signed [BASIS_BITS-1:0]  basis_t;
  typedef logic signed [WGT_BITS-1:0]    weight_t;
  typedef logic signed [K_BITS-1:0]      kconst_t;
  typedef weight_t wvec_t [NUM_COEFFS];

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  typedef enum logic {
    MODE_RADIANCE   = 1'b0,
    MODE_IRRADIANCE = 1'b1
  } mode_t;

  typedef struct packed {
    kind_t                kind;
    mode_t                mode;
    logic [IDX_BITS-1:0]  coeff_index;
    coeff_t               coeff_r;
    coeff_t               coeff_g;
    coeff_t               coeff_b;
    normal_t              normal_x;
    normal_t              normal_y;
    normal_t              normal_z;
  } in_item_t;

  typedef struct packed {
    coeff_t out_r;
    coeff_t out_g;
    coeff_t out_b;
    logic   saturated;
  } out_item_t;

  // stage enables and coefficient write strobe
  typedef struct packed {
    logic                en1;
    logic                en2;
    logic                en3;
    logic                en4;
    logic                en5;
    logic                st_we;
    logic [IDX_BITS-1:0] st_idx;
  } pipe_ctl_t;

  // constants, unsigned with 20 fraction bits
  localparam int K_R0_I  = 295798;
  localparam int K_R1_I  = 512337;
  localparam int K_R2A_I = 1145620;
  localparam int K_R2B_I = 330712;
  localparam int K_R2C_I = 572810;
  localparam int K_I0_I  = 929276;
  localparam int K_I1_I  = 1073038;
  localparam int K_I2A_I = 899768;
  localparam int K_I2B_I = 449884;
  localparam int K_I6A_I = 779223;
  localparam int K_I6B_I = 259741;

  localparam kconst_t K_R1  = K_BITS'(K_R1_I);
  localparam kconst_t K_R2A = K_BITS'(K_R2A_I);
  localparam kconst_t K_R2B = K_BITS'(K_R2B_I);
  localparam kconst_t K_R2C = K_BITS'(K_R2C_I);
  localparam kconst_t K_I1  = K_BITS'(K_I1_I);
  localparam kconst_t K_I2A = K_BITS'(K_I2A_I);
  localparam kconst_t K_I2B = K_BITS'(K_I2B_I);
  localparam kconst_t K_I6A = K_BITS'(K_I6A_I);

  localparam longint W0_RAD_L =
    (longint'(K_R0_I) * ONE_16 + (longint'(1) <<< (KSH - 1))) >>> KSH;
  localparam longint W0_IRR_L =
    (longint'(K_I0_I) * ONE_16 + (longint'(1) <<< (KSH - 1))) >>> KSH;
  localparam weight_t W0_RAD = WGT_BITS'(W0_RAD_L);
  localparam weight_t W0_IRR = WGT_BITS'(W0_IRR_L);

  localparam logic signed [KMUL_BITS-1:0] C6_IRR =
    KMUL_BITS'(longint'(K_I6B_I) * ONE_16);
  localparam logic signed [KMUL_BITS-1:0] HALF_K   = KMUL_BITS'(1) <<< (KSH - 1);
  localparam logic signed [NPROD_BITS-1:0] HALF_N  = NPROD_BITS'(1) <<< (NSHIFT - 1);
  localparam logic signed [ACC_BITS-1:0] HALF_OUT  = ACC_BITS'(1) <<< (OUT_FRAC - 1);

  localparam coeff_t SAT_HI = {1'b0, {(COEFF_BITS-1){1'b1}}};
  localparam coeff_t SAT_LO = {1'b1, {(COEFF_BITS-1){1'b0}}};

endpackage

@@ design/sh2e_basis.sv @@
// Basis products of the normal and the nine mode-dependent weights (two stages).
module sh2e_basis (
  input  logic               clk,
  input  sh2e_pkg::pipe_ctl_t ctl,
  input  sh2e_pkg::mode_t    mode,
  input  sh2e_pkg::normal_t  nx,
  input  sh2e_pkg::normal_t  ny,
  input  sh2e_pkg::normal_t  nz,
  output sh2e_pkg::wvec_t    w_r
);
  import sh2e_pkg::*;

  function automatic basis_t rnd_norm(input logic signed [NPROD_BITS-1:0] p);
    logic signed [NPROD_BITS-1:0] s;
    s = p + HALF_N;
    return BASIS_BITS'(s >>> NSHIFT);
  endfunction

  function automatic weight_t wmul(input kconst_t k,
                                   input logic signed [BEXT_BITS-1:0] b,
                                   input logic signed [KMUL_BITS-1:0] off);
    logic signed [KMUL_BITS-1:0] p;
    p = KMUL_BITS'(k) * KMUL_BITS'(b) - off + HALF_K;
    return WGT_BITS'(p >>> KSH);
  endfunction

  logic signed [NPROD_BITS-1:0] ex, ey, ez;
  basis_t lx_r, ly_r, lz_r, xy_r, yz_r, xz_r, xx_r, yy_r, zz_r;
  mode_t  mode1_r;

  always_comb begin
    ex = NPROD_BITS'(nx);
    ey = NPROD_BITS'(ny);
    ez = NPROD_BITS'(nz);
  end

  // stage 1: products of normal components in 16 fraction bits
  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      mode1_r <= mode;
      lx_r    <= rnd_norm(ex <<< NFRAC);
      ly_r    <= rnd_norm(ey <<< NFRAC);
      lz_r    <= rnd_norm(ez <<< NFRAC);
      xy_r    <= rnd_norm(ex * ey);
      yz_r    <= rnd_norm(ey * ez);
      xz_r    <= rnd_norm(ex * ez);
      xx_r    <= rnd_norm(ex * ex);
      yy_r    <= rnd_norm(ey * ey);
      zz_r    <= rnd_norm(ez * ez);
    end
  end

  kconst_t k1, k2, k6, k8;
  weight_t w0;
  logic signed [BEXT_BITS-1:0] b6, b8;
  logic signed [KMUL_BITS-1:0] off6;

  always_comb begin
    b8 = BEXT_BITS'(xx_r) - BEXT_BITS'(yy_r);
    unique case (mode1_r)
      MODE_RADIANCE: begin
        w0   = W0_RAD;
        k1   = K_R1;
        k2   = K_R2A;
        k6   = K_R2B;
        k8   = K_R2C;
        b6   = BEXT_BITS'(3 * BEXT_BITS'(zz_r) - ONE_16);
        off6 = KMUL_BITS'(0);
      end
      MODE_IRRADIANCE: begin
        w0   = W0_IRR;
        k1   = K_I1;
        k2   = K_I2A;
        k6   = K_I6A;
        k8   = K_I2B;
        b6   = BEXT_BITS'(zz_r);
        off6 = C6_IRR;
      end
      default: begin
        w0   = W0_RAD;
        k1   = K_R1;
        k2   = K_R2A;
        k6   = K_R2B;
        k8   = K_R2C;
        b6   = BEXT_BITS'(zz_r);
        off6 = KMUL_BITS'(0);
      end
    endcase
  end

  // stage 2: constant times basis, band order 0..8
  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      w_r[0] <= w0;
      w_r[1] <= wmul(k1, BEXT_BITS'(ly_r), KMUL_BITS'(0));
      w_r[2] <= wmul(k1, BEXT_BITS'(lz_r), KMUL_BITS'(0));
      w_r[3] <= wmul(k1, BEXT_BITS'(lx_r), KMUL_BITS'(0));
      w_r[4] <= wmul(k2, BEXT_BITS'(xy_r), KMUL_BITS'(0));
      w_r[5] <= wmul(k2, BEXT_BITS'(yz_r), KMUL_BITS'(0));
      w_r[6] <= wmul(k6, b6, off6);
      w_r[7] <= wmul(k2, BEXT_BITS'(xz_r), KMUL_BITS'(0));
      w_r[8] <= wmul(k8, b8, KMUL_BITS'(0));
    end
  end

endmodule

@@ design/sh2e_lane.sv @@
// One color channel: coefficient column, nine products, sum, round and clip.
module sh2e_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  sh2e_pkg::pipe_ctl_t ctl,
  input  sh2e_pkg::coeff_t    wr_data,
  input  sh2e_pkg::wvec_t     w,
  output sh2e_pkg::coeff_t    res,
  output logic                sat
);
  import sh2e_pkg::*;

  coeff_t store_r [NUM_COEFFS];
  logic signed [CPROD_BITS-1:0] prod_r [NUM_COEFFS];
  logic signed [PSUM_BITS-1:0]  psum_r [3];
  logic signed [ACC_BITS-1:0]   acc, rs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        store_r[i] <= '0;
      end
    end else if (ctl.st_we) begin
      store_r[ctl.st_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        prod_r[i] <= CPROD_BITS'(store_r[i]) * CPROD_BITS'(w[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en4) begin
      for (int g = 0; g < 3; g++) begin
        psum_r[g] <= PSUM_BITS'(prod_r[3*g]) + PSUM_BITS'(prod_r[3*g+1])
                   + PSUM_BITS'(prod_r[3*g+2]);
      end
    end
  end

  always_comb begin
    acc = ACC_BITS'(psum_r[0]) + ACC_BITS'(psum_r[1]) + ACC_BITS'(psum_r[2]) + HALF_OUT;
    rs  = acc >>> OUT_FRAC;
    priority if (rs > ACC_BITS'(SAT_HI)) begin
      res = SAT_HI;
      sat = 1'b1;
    end else if (rs < ACC_BITS'(SAT_LO)) begin
      res = SAT_LO;
      sat = 1'b1;
    end else begin
      res = COEFF_BITS'(rs);
      sat = 1'b0;
    end
  end

endmodule

@@ design/sh2e_merge.sv @@
// Output register: packs the three lane results and merges their clip flags.
module sh2e_merge (
  input  logic                 clk,
  input  logic                 en,
  input  sh2e_pkg::coeff_t     res_r,
  input  sh2e_pkg::coeff_t     res_g,
  input  sh2e_pkg::coeff_t     res_b,
  input  logic [2:0]           sat,
  output sh2e_pkg::out_item_t  data_r
);
  import sh2e_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      data_r.out_r     <= res_r;
      data_r.out_g     <= res_g;
      data_r.out_b     <= res_b;
      data_r.saturated <= |sat;
    end
  end

endmodule

@@ design/sh_order2_rgb_evaluate.sv @@
// Order-2 spherical-harmonic RGB evaluator, top level.
// An evaluate word passes each register of the five-stage pipeline, then shows on out_valid.
// Throughput: one word per cycle, loads and evaluates alike, while out_stall is low.
// A load word with index under 9 writes the coefficient column at stage 3 and produces no result.
// Each stage advances when it is empty or its successor advances, so bubbles are squeezed out.
// Reset (rst_n low, synchronous) empties the pipeline and zeroes all nine coefficients.
module sh_order2_rgb_evaluate (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sh2e_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sh2e_pkg::out_item_t  out_data
);
  import sh2e_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, ov_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  pipe_ctl_t ctl;

  kind_t               kind1_r, kind2_r;
  logic [IDX_BITS-1:0] idx1_r, idx2_r;
  coeff_t              c1_r [NUM_CHAN];
  coeff_t              c2_r [NUM_CHAN];

  wvec_t      w_r;
  coeff_t     res [NUM_CHAN];
  logic [2:0] sat;

  always_comb begin
    rdy_o = !ov_r || !out_stall;
    rdy4  = !v4_r || rdy_o;
    rdy3  = !v3_r || rdy4;
    rdy2  = !v2_r || rdy3;
    rdy1  = !v1_r || rdy2;

    ctl.en1    = rdy1;
    ctl.en2    = rdy2;
    ctl.en3    = rdy3;
    ctl.en4    = rdy4;
    ctl.en5    = rdy_o;
    ctl.st_we  = rdy3 && v2_r && (kind2_r == KIND_LOAD) &&
                 (idx2_r < IDX_BITS'(NUM_COEFFS));
    ctl.st_idx = idx2_r;
  end

  assign in_stall  = !rdy1;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      // drop load words here: they end at the coefficient write
      if (rdy3) begin
        v3_r <= v2_r && (kind2_r == KIND_EVAL);
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy_o) begin
        ov_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      kind1_r <= in_data.kind;
      idx1_r  <= in_data.coeff_index;
      c1_r[0] <= in_data.coeff_r;
      c1_r[1] <= in_data.coeff_g;
      c1_r[2] <= in_data.coeff_b;
    end
    if (rdy2) begin
      kind2_r <= kind1_r;
      idx2_r  <= idx1_r;
      c2_r    <= c1_r;
    end
  end

  sh2e_basis u_basis (
    .clk  (clk),
    .ctl  (ctl),
    .mode (in_data.mode),
    .nx   (in_data.normal_x),
    .ny   (in_data.normal_y),
    .nz   (in_data.normal_z),
    .w_r  (w_r)
  );

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    sh2e_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_data (c2_r[c]),
      .w       (w_r),
      .res     (res[c]),
      .sat     (sat[c])
    );
  end

  sh2e_merge u_merge (
    .clk    (clk),
    .en     (ctl.en5),
    .res_r  (res[0]),
    .res_g  (res[1]),
    .res_b  (res[2]),
    .sat    (sat),
    .data_r (out_data)
  );

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && ov_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_eval_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy3 && v2_r && (kind2_r == KIND_EVAL)) |=> v3_r)
    else $error("evaluate word lost at stage 3");

  a_load_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy3 && v2_r && (kind2_r == KIND_LOAD)) |=> !v3_r)
    else $error("load word reached the lanes");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.out_r == SAT_HI || out_data.out_r == SAT_LO ||
       out_data.out_g == SAT_HI || out_data.out_g == SAT_LO ||
       out_data.out_b == SAT_HI || out_data.out_b == SAT_LO))
    else $error("clip flag set with no channel at a limit");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the order-2 SH RGB evaluator: directed table, then random words.
`timescale 1ns / 100ps

module tb_top;
  import sh2e_pkg::*;

  localparam int  RAND_WORDS   = 1350;
  localparam int  DRAIN_CYCLES = 20;
  localparam int  LIMIT        = 600000;
  localparam int  C_MAX        = 8388607;
  localparam int  C_MIN        = -8388608;

  // basis constants, unsigned with 20 fraction bits
  localparam longint RAD_L0  = 295798;
  localparam longint RAD_L1  = 512337;
  localparam longint RAD_L2X = 1145620;
  localparam longint RAD_L2Z = 330712;
  localparam longint RAD_L2D = 572810;
  localparam longint IRR_L0  = 929276;
  localparam longint IRR_L1  = 1073038;
  localparam longint IRR_L2X = 899768;
  localparam longint IRR_L2D = 449884;
  localparam longint IRR_ZSQ = 779223;
  localparam longint IRR_ZOF = 259741;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t val;
  } vec_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  longint    sh_coeffs [NUM_COEFFS][NUM_CHAN];
  out_item_t rgb_pending [$];
  vec_row_t  dir_rows [$];
  int        mismatches;
  int        cycles;
  int        burst_left;

  sh_order2_rgb_evaluate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // round to nearest, ties up, dropping s fraction bits
  function automatic longint round_off(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint nprod(longint a, longint b);
    return round_off(a * b, 2 * NFRAC - OUT_FRAC);
  endfunction

  function automatic longint kmul(longint k, longint basis);
    return round_off(k * basis, KSH);
  endfunction

  function automatic out_item_t sh_eval(mode_t m, normal_t nx, normal_t ny, normal_t nz);
    longint    x, y, z, one, lx, ly, lz, xy, yz, xz, xx, yy, zz, acc, r, hi, lo;
    longint    w [NUM_COEFFS];
    coeff_t    ch [NUM_CHAN];
    out_item_t res;
    x   = nx;
    y   = ny;
    z   = nz;
    one = longint'(1) <<< NFRAC;
    lx  = nprod(x, one);
    ly  = nprod(y, one);
    lz  = nprod(z, one);
    xy  = nprod(x, y);
    yz  = nprod(y, z);
    xz  = nprod(x, z);
    xx  = nprod(x, x);
    yy  = nprod(y, y);
    zz  = nprod(z, z);
    if (m == MODE_RADIANCE) begin
      w[0] = kmul(RAD_L0, ONE_16);
      w[1] = kmul(RAD_L1, ly);
      w[2] = kmul(RAD_L1, lz);
      w[3] = kmul(RAD_L1, lx);
      w[4] = kmul(RAD_L2X, xy);
      w[5] = kmul(RAD_L2X, yz);
      w[6] = kmul(RAD_L2Z, 3 * zz - ONE_16);
      w[7] = kmul(RAD_L2X, xz);
      w[8] = kmul(RAD_L2D, xx - yy);
    end else begin
      w[0] = kmul(IRR_L0, ONE_16);
      w[1] = kmul(IRR_L1, ly);
      w[2] = kmul(IRR_L1, lz);
      w[3] = kmul(IRR_L1, lx);
      w[4] = kmul(IRR_L2X, xy);
      w[5] = kmul(IRR_L2X, yz);
      w[6] = round_off(IRR_ZSQ * zz - IRR_ZOF * ONE_16, KSH);
      w[7] = kmul(IRR_L2X, xz);
      w[8] = kmul(IRR_L2D, xx - yy);
    end
    hi = (longint'(1) <<< (COEFF_BITS - 1)) - 1;
    lo = -hi - 1;
    res.saturated = 1'b0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc = 0;
      for (int i = 0; i < NUM_COEFFS; i++) acc += sh_coeffs[i][c] * w[i];
      r = round_off(acc, OUT_FRAC);
      if (r > hi) begin
        r = hi;
        res.saturated = 1'b1;
      end
      if (r < lo) begin
        r = lo;
        res.saturated = 1'b1;
      end
      ch[c] = coeff_t'(r);
    end
    res.out_r = ch[0];
    res.out_g = ch[1];
    res.out_b = ch[2];
    return res;
  endfunction

  task automatic row(kind_t k, mode_t m, int idx, int r, int g, int b,
                     int x, int y, int z, bit zero_result);
    vec_row_t v;
    v.word.kind        = k;
    v.word.mode        = m;
    v.word.coeff_index = IDX_BITS'(idx);
    v.word.coeff_r     = coeff_t'(r);
    v.word.coeff_g     = coeff_t'(g);
    v.word.coeff_b     = coeff_t'(b);
    v.word.normal_x    = normal_t'(x);
    v.word.normal_y    = normal_t'(y);
    v.word.normal_z    = normal_t'(z);
    v.typed            = zero_result;
    v.val              = '0;
    dir_rows.push_back(v);
  endtask

  function automatic coeff_t rand_coeff();
    coeff_t v;
    case ($urandom_range(0, 5))
      0:       v = coeff_t'($urandom);
      1:       v = $urandom_range(0, 1) ? SAT_HI : SAT_LO;
      default: v = coeff_t'($urandom_range(0, 1 << 18) - (1 << 18));
    endcase
    return v;
  endfunction

  function automatic in_item_t rand_word();
    in_item_t w;
    int       nx, ny, nz;
    real      rest;
    w.kind        = ($urandom_range(0, 3) == 0) ? KIND_LOAD : KIND_EVAL;
    w.mode        = $urandom_range(0, 1) ? MODE_IRRADIANCE : MODE_RADIANCE;
    w.coeff_index = ($urandom_range(0, 7) == 0) ? IDX_BITS'($urandom_range(9, 15))
                                                 : IDX_BITS'($urandom_range(0, 8));
    w.coeff_r     = rand_coeff();
    w.coeff_g     = rand_coeff();
    w.coeff_b     = rand_coeff();
    if ($urandom_range(0, 3) == 0) begin
      w.normal_x = normal_t'($urandom);
      w.normal_y = normal_t'($urandom);
      w.normal_z = normal_t'($urandom);
    end else begin
      // roughly unit length, third component solved, axes rotated
      nx   = int'($urandom_range(0, 46340)) - 23170;
      ny   = int'($urandom_range(0, 46340)) - 23170;
      rest = $sqrt(1073741824.0 - real'(nx * nx) - real'(ny * ny));
      nz   = (rest > 32767.0) ? 32767 : int'(rest);
      if ($urandom_range(0, 1)) nz = -nz;
      case ($urandom_range(0, 2))
        0: begin
          w.normal_x = normal_t'(nx); w.normal_y = normal_t'(ny); w.normal_z = normal_t'(nz);
        end
        1: begin
          w.normal_x = normal_t'(nz); w.normal_y = normal_t'(nx); w.normal_z = normal_t'(ny);
        end
        default: begin
          w.normal_x = normal_t'(ny); w.normal_y = normal_t'(nz); w.normal_z = normal_t'(nx);
        end
      endcase
    end
    return w;
  endfunction

  // hold the word until accepted, then update the coefficient copy or queue the result
  task automatic offer(in_item_t w, bit typed, out_item_t typed_val);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.kind == KIND_LOAD) begin
      if (w.coeff_index < NUM_COEFFS) begin
        sh_coeffs[w.coeff_index][0] = w.coeff_r;
        sh_coeffs[w.coeff_index][1] = w.coeff_g;
        sh_coeffs[w.coeff_index][2] = w.coeff_b;
      end
    end else if (typed) begin
      rgb_pending.push_back(typed_val);
    end else begin
      rgb_pending.push_back(sh_eval(w.mode, w.normal_x, w.normal_y, w.normal_z));
    end
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
    end
  endtask

  task automatic check_field(string name, coeff_t want, coeff_t got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    mismatches = 0;
    cycles     = 0;
    burst_left = 5;
    for (int i = 0; i < NUM_COEFFS; i++)
      for (int c = 0; c < NUM_CHAN; c++) sh_coeffs[i][c] = 0;

    // empty store: evaluates give zero whatever the normal
    row(KIND_EVAL, MODE_RADIANCE,   0,  0, 0, 0, 0, 0, 0, 1);
    row(KIND_EVAL, MODE_IRRADIANCE, 15, -1, -1, -1, -32768, -32768, -32768, 1);
    row(KIND_EVAL, MODE_RADIANCE,   8,  C_MAX, C_MIN, 0, 32767, 32767, 32767, 1);
    // out-of-range index writes nothing
    row(KIND_LOAD, MODE_IRRADIANCE, 9,  C_MAX, C_MAX, C_MAX, 32767, -32768, 0, 0);
    row(KIND_LOAD, MODE_RADIANCE,   15, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0);
    row(KIND_EVAL, MODE_IRRADIANCE, 0,  0, 0, 0, 0, 0, 32767, 1);
    // band 0 and the z^2 term at opposite extremes: clip high and low
    row(KIND_LOAD, MODE_IRRADIANCE, 0,  C_MAX, C_MIN, 1, -32768, 32767, -1, 0);
    row(KIND_LOAD, MODE_RADIANCE,   6,  C_MIN, C_MAX, -1, 0, 0, 0, 0);
    row(KIND_EVAL, MODE_IRRADIANCE, 3,  C_MAX, C_MAX, C_MAX, 0, 0, 0, 0);
    row(KIND_EVAL, MODE_RADIANCE,   12, 0, 0, 0, 0, 0, 32767, 0);
    row(KIND_LOAD, MODE_RADIANCE,   1,  65536, -65536, 32768, 0, 0, 0, 0);
    row(KIND_LOAD, MODE_RADIANCE,   2,  -131072, 98304, 1000, 0, 0, 0, 0);
    row(KIND_LOAD, MODE_IRRADIANCE, 3,  20000, -20000, 65535, 0, 0, 0, 0);
    row(KIND_LOAD, MODE_RADIANCE,   4,  -65536, 13107, -7, 0, 0, 0, 0);
    row(KIND_LOAD, MODE_IRRADIANCE, 5,  196608, 0, -196608, 0, 0, 0, 0);
    row(KIND_LOAD, MODE_RADIANCE,   7,  -1, 1, 327680, 0, 0, 0, 0);
    row(KIND_LOAD, MODE_RADIANCE,   8,  45875, -45875, 0, 0, 0, 0, 0);
    row(KIND_EVAL, MODE_RADIANCE,   0,  0, 0, 0, 32767, 32767, 32767, 0);
    row(KIND_EVAL, MODE_IRRADIANCE, 0,  0, 0, 0, -32768, 32767, -32768, 0);
    row(KIND_EVAL, MODE_RADIANCE,   0,  0, 0, 0, -32768, -32768, -32768, 0);
    row(KIND_EVAL, MODE_IRRADIANCE, 0,  0, 0, 0, 0, -32768, 0, 0);
    row(KIND_EVAL, MODE_RADIANCE,   0,  0, 0, 0, 23170, 23170, 0, 0);
    row(KIND_EVAL, MODE_IRRADIANCE, 0,  0, 0, 0, 0, 0, -32768, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // sender: directed table, then random words, in bursts
  initial begin : sender
    do @(posedge clk); while (!rst_n);
    foreach (dir_rows[i]) begin
      offer(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].val);
      pace();
    end
    for (int n = 0; n < RAND_WORDS; n++) begin
      offer(rand_word(), 1'b0, '0);
      pace();
    end
    in_valid <= 1'b0;
    while (rgb_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // receiver: stretches of free flow, light and heavy stall, one long hold-off
  initial begin : receiver
    int style;
    int stretch;
    bit held;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      style   = $urandom_range(0, 3);
      stretch = $urandom_range(20, 150);
      if (!held && cycles > 400) begin
        held    = 1'b1;
        style   = 4;
        stretch = 120;
      end
      repeat (stretch) begin
        case (style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          3:       out_stall <= $urandom_range(0, 1);
          default: out_stall <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : rgb_monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_pending.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with none expected, got r %0d g %0d b %0d sat %0b",
                 $time, out_data.out_r, out_data.out_g, out_data.out_b, out_data.saturated);
      end else begin
        want = rgb_pending.pop_front();
        check_field("red", want.out_r, out_data.out_r);
        check_field("green", want.out_g, out_data.out_g);
        check_field("blue", want.out_b, out_data.out_b);
        check_field("saturated", coeff_t'(want.saturated), coeff_t'(out_data.saturated));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

@@ sh_order2_rgb_evaluate.f @@
design/sh2e_pkg.sv
design/sh2e_basis.sv
design/sh2e_lane.sv
design/sh2e_merge.sv
design/sh_order2_rgb_evaluate.sv
tb/tb_top.sv
